### design/aqts_pkg.sv
// Package for the affinity quantum thread scheduler.
// Sizes, command codes, datapath operation codes and the controller/datapath structs.
// No dependencies.
package aqts_pkg;

    localparam int NUM_THREADS = 32;
    localparam int NUM_CORES   = 8;
    localparam int TIME_BITS   = 32;
    localparam int TW          = $clog2(NUM_THREADS);
    localparam int CW          = $clog2(NUM_CORES);

    localparam logic [31:0] QUANTUM_RESET = 32'd100000;
    localparam logic [3:0]  CORES_RESET   = 4'd8;

    // configuration register indexes
    localparam logic [1:0] IDX_QUANTUM = 2'd0;
    localparam logic [1:0] IDX_CORES   = 2'd1;

    // event commands
    localparam logic [3:0] CMD_CREATE  = 4'd0;
    localparam logic [3:0] CMD_SETAFF  = 4'd1;
    localparam logic [3:0] CMD_GETAFF  = 4'd2;
    localparam logic [3:0] CMD_YIELD   = 4'd3;
    localparam logic [3:0] CMD_START   = 4'd4;
    localparam logic [3:0] CMD_STALL   = 4'd5;
    localparam logic [3:0] CMD_RESUME  = 4'd6;
    localparam logic [3:0] CMD_EXIT    = 4'd7;
    localparam logic [3:0] CMD_TICK    = 4'd8;

    typedef struct packed {
        logic [3:0]           command;
        logic [TW-1:0]        thread_index;
        logic [TW-1:0]        caller_index;
        logic [7:0]           affinity_mask;
        logic                 mask_given;
        logic [TIME_BITS-1:0] event_time;
    } t_item;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_REJECT, OP_CREATE1, OP_CREATE2, OP_SETAFF1, OP_GETAFF,
        OP_RUN1, OP_STOP1, OP_SLICE_CLR_ON, OP_YIELD_SET, OP_RS_BEGIN, OP_RS_SCAN,
        OP_RS_OUT, OP_RS_COMMIT, OP_TICK_INIT, OP_TICK_DEC, OP_TICK_NEXT, OP_TICK_END,
        OP_REPLY
    } t_op;

    // where a reschedule takes its core from
    typedef enum logic [1:0] {
        SRC_ON, SRC_FREE, SRC_YC, SRC_TICK
    } t_src;

    typedef struct packed {
        t_op  op;
        t_src src;
    } t_dp_cmd;

    typedef struct packed {
        logic [3:0] cmd;
        logic       created;
        logic       runnable;
        logic       on_none;
        logic       on_allowed;
        logic       yc_allowed;
        logic       self;
        logic       mask_bad;
        logic       free_valid;
        logic       occ_start;
        logic       scan_last;
        logic       need_out;
        logic       need_in;
        logic       tick_need;
        logic       tick_last;
        logic       out_free;
    } t_dp_stat;

endpackage

### design/aqts_if.sv
// Channel interfaces of the scheduler: event items in, result items out.
// Depends on aqts_pkg for sizes.
interface aqts_in_if;
    logic                          valid;
    logic                          ready;
    logic [3:0]                    command;
    logic [aqts_pkg::TW-1:0]       thread_index;
    logic [aqts_pkg::TW-1:0]       caller_index;
    logic [7:0]                    affinity_mask;
    logic                          mask_given;
    logic [aqts_pkg::TIME_BITS-1:0] event_time;

    modport source (output valid, command, thread_index, caller_index, affinity_mask,
                    mask_given, event_time, input ready);
    modport sink   (input valid, command, thread_index, caller_index, affinity_mask,
                    mask_given, event_time, output ready);
endinterface

interface aqts_out_if;
    logic                    valid;
    logic                    ready;
    logic                    result_kind;
    logic [aqts_pkg::TW-1:0] moved_thread;
    logic [aqts_pkg::CW-1:0] core_index;
    logic                    core_valid;
    logic                    reply_ok;
    logic [7:0]              reply_mask;
    logic                    last_result;

    modport source (output valid, result_kind, moved_thread, core_index, core_valid,
                    reply_ok, reply_mask, last_result, input ready);
    modport sink   (input valid, result_kind, moved_thread, core_index, core_valid,
                    reply_ok, reply_mask, last_result, output ready);
endinterface

### design/aqts_ctrl.sv
// Sequencer of the scheduler: dispatches events, runs reschedules and the tick sweep.
// Depends on aqts_pkg; drives aqts_dp through t_dp_cmd and reads t_dp_stat.
module aqts_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  aqts_pkg::t_dp_stat i_stat,
    output aqts_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [15:0] {
        S_IDLE      = 16'h0001,
        S_DISP      = 16'h0002,
        S_CR2       = 16'h0004,
        S_SA2       = 16'h0008,
        S_YCHK      = 16'h0010,
        S_FREE_RS   = 16'h0020,
        S_ON_RS     = 16'h0040,
        S_RS_BEGIN  = 16'h0080,
        S_RS_CHK    = 16'h0100,
        S_RS_SCAN   = 16'h0200,
        S_RS_OUT    = 16'h0400,
        S_RS_COMMIT = 16'h0800,
        S_Y2        = 16'h1000,
        S_TCHK      = 16'h2000,
        S_TNEXT     = 16'h4000,
        S_REPLY     = 16'h8000
    } t_state;

    // what follows a finished reschedule
    typedef enum logic [1:0] {
        PH_DONE, PH_Y2, PH_TICK
    } t_phase;

    t_state         r_state, n_state;
    t_phase         r_phase, n_phase;
    aqts_pkg::t_src r_src, n_src;
    t_state         w_ret;

    assign o_ready = (r_state == S_IDLE);

    // return point after a reschedule
    always_comb begin
        unique case (r_phase)
            PH_Y2:   w_ret = S_Y2;
            PH_TICK: w_ret = S_TNEXT;
            default: w_ret = S_REPLY;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_src     = r_src;
        o_cmd.op  = aqts_pkg::OP_NOP;
        o_cmd.src = r_src;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = aqts_pkg::OP_LOAD;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                if (i_stat.cmd > aqts_pkg::CMD_TICK ||
                    (i_stat.cmd >= aqts_pkg::CMD_YIELD && i_stat.cmd <= aqts_pkg::CMD_EXIT &&
                     !i_stat.created)) begin
                    o_cmd.op = aqts_pkg::OP_REJECT;
                    n_state  = S_REPLY;
                end else begin
                    unique case (i_stat.cmd) inside
                        aqts_pkg::CMD_CREATE: begin
                            if (i_stat.created) begin
                                o_cmd.op = aqts_pkg::OP_REJECT;
                                n_state  = S_REPLY;
                            end else begin
                                o_cmd.op = aqts_pkg::OP_CREATE1;
                                n_state  = S_CR2;
                            end
                        end
                        aqts_pkg::CMD_SETAFF: begin
                            o_cmd.op = aqts_pkg::OP_SETAFF1;
                            n_state  = S_SA2;
                        end
                        aqts_pkg::CMD_GETAFF: begin
                            o_cmd.op = aqts_pkg::OP_GETAFF;
                            n_state  = S_REPLY;
                        end
                        aqts_pkg::CMD_YIELD: begin
                            n_state = S_YCHK;
                        end
                        aqts_pkg::CMD_START, aqts_pkg::CMD_RESUME: begin
                            o_cmd.op = aqts_pkg::OP_RUN1;
                            n_state  = S_FREE_RS;
                        end
                        aqts_pkg::CMD_STALL, aqts_pkg::CMD_EXIT: begin
                            o_cmd.op = aqts_pkg::OP_STOP1;
                            n_state  = S_ON_RS;
                        end
                        aqts_pkg::CMD_TICK: begin
                            o_cmd.op = aqts_pkg::OP_TICK_INIT;
                            n_state  = S_TCHK;
                        end
                        default: begin
                            o_cmd.op = aqts_pkg::OP_REJECT;
                            n_state  = S_REPLY;
                        end
                    endcase
                end
            end
            S_CR2: begin
                o_cmd.op = aqts_pkg::OP_CREATE2;
                n_state  = S_REPLY;
            end
            // set_affinity follow-up once the mask is stored
            S_SA2: begin
                if (i_stat.mask_bad || !i_stat.created) begin
                    n_state = S_REPLY;
                end else if (i_stat.self) begin
                    n_state = S_YCHK;
                end else if (!i_stat.on_none && !i_stat.on_allowed) begin
                    o_cmd.op = aqts_pkg::OP_SLICE_CLR_ON;
                    n_state  = S_REPLY;
                end else if (i_stat.runnable && i_stat.on_none) begin
                    n_state = S_FREE_RS;
                end else begin
                    n_state = S_REPLY;
                end
            end
            S_YCHK: begin
                if (i_stat.on_none) begin
                    n_state = S_REPLY;
                end else begin
                    o_cmd.op = aqts_pkg::OP_YIELD_SET;
                    n_phase  = PH_Y2;
                    n_src    = aqts_pkg::SRC_YC;
                    n_state  = S_RS_BEGIN;
                end
            end
            S_FREE_RS: begin
                if (i_stat.free_valid) begin
                    n_src   = aqts_pkg::SRC_FREE;
                    n_phase = PH_DONE;
                    n_state = S_RS_BEGIN;
                end else begin
                    n_state = S_REPLY;
                end
            end
            S_ON_RS: begin
                if (!i_stat.on_none) begin
                    n_src   = aqts_pkg::SRC_ON;
                    n_phase = PH_DONE;
                    n_state = S_RS_BEGIN;
                end else begin
                    n_state = S_REPLY;
                end
            end
            // reschedule of one core
            S_RS_BEGIN: begin
                o_cmd.op = aqts_pkg::OP_RS_BEGIN;
                n_state  = S_RS_CHK;
            end
            S_RS_CHK: begin
                n_state = i_stat.occ_start ? w_ret : S_RS_SCAN;
            end
            S_RS_SCAN: begin
                o_cmd.op = aqts_pkg::OP_RS_SCAN;
                if (i_stat.scan_last) begin
                    n_state = S_RS_OUT;
                end
            end
            S_RS_OUT: begin
                if (!i_stat.need_out) begin
                    n_state = S_RS_COMMIT;
                end else if (i_stat.out_free) begin
                    o_cmd.op = aqts_pkg::OP_RS_OUT;
                    n_state  = S_RS_COMMIT;
                end
            end
            S_RS_COMMIT: begin
                if (!i_stat.need_in || i_stat.out_free) begin
                    o_cmd.op = aqts_pkg::OP_RS_COMMIT;
                    n_state  = w_ret;
                end
            end
            S_Y2: begin
                if (!i_stat.yc_allowed && i_stat.free_valid) begin
                    n_src   = aqts_pkg::SRC_FREE;
                    n_phase = PH_DONE;
                    n_state = S_RS_BEGIN;
                end else begin
                    n_state = S_REPLY;
                end
            end
            // tick sweep over the cores in use
            S_TCHK: begin
                if (i_stat.tick_need) begin
                    n_src   = aqts_pkg::SRC_TICK;
                    n_phase = PH_TICK;
                    n_state = S_RS_BEGIN;
                end else begin
                    o_cmd.op = aqts_pkg::OP_TICK_DEC;
                    n_state  = S_TNEXT;
                end
            end
            S_TNEXT: begin
                if (i_stat.tick_last) begin
                    o_cmd.op = aqts_pkg::OP_TICK_END;
                    n_state  = S_REPLY;
                end else begin
                    o_cmd.op = aqts_pkg::OP_TICK_NEXT;
                    n_state  = S_TCHK;
                end
            end
            S_REPLY: begin
                if (i_stat.out_free) begin
                    o_cmd.op = aqts_pkg::OP_REPLY;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_DONE;
            r_src   <= aqts_pkg::SRC_ON;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_src   <= n_src;
        end
    end

endmodule

### design/aqts_dp.sv
// Datapath of the scheduler: thread and core tables, scan unit, config and result register.
// Depends on aqts_pkg and aqts_out_if; operated by aqts_ctrl.
module aqts_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  aqts_pkg::t_item      i_item,
    input  aqts_pkg::t_dp_cmd    i_cmd,
    output aqts_pkg::t_dp_stat   o_stat,
    aqts_out_if.source           o_res
);

    localparam int NT = aqts_pkg::NUM_THREADS;
    localparam int NC = aqts_pkg::NUM_CORES;
    localparam int TW = aqts_pkg::TW;
    localparam int CW = aqts_pkg::CW;
    localparam int TB = aqts_pkg::TIME_BITS;

    // thread table
    logic [7:0]    r_aff   [NT];
    logic          r_run   [NT];
    logic          r_start [NT];
    logic          r_cre   [NT];
    logic          r_onv   [NT];   // 1: not on any core
    logic [CW-1:0] r_onc   [NT];
    logic [TB-1:0] r_last  [NT];
    // core table
    logic          r_occv  [NC];
    logic [TW-1:0] r_occ   [NC];
    logic [31:0]   r_slice [NC];
    logic [TB-1:0] r_prev;
    logic [CW-1:0] r_nic;
    logic [31:0]   r_quant;
    logic [3:0]    r_ncfg;
    // current event
    logic [3:0]    r_cmd;
    logic [TW-1:0] r_t, r_caller;
    logic [7:0]    r_mask;
    logic          r_given;
    logic [TB-1:0] r_now;
    logic          r_ok, r_rcv;
    logic [CW-1:0] r_rcore;
    logic [7:0]    r_rmask;
    // reschedule and tick sweep
    logic [CW-1:0] r_rc, r_yc, r_tc;
    logic [TW-1:0] r_st, r_pick;
    logic          r_pv;
    logic [TB-1:0] r_best;
    // result register
    logic          r_ov, r_okind, r_ocv, r_ook, r_olast;
    logic [TW-1:0] r_oth;
    logic [CW-1:0] r_ocore;
    logic [7:0]    r_omask;

    logic [3:0]    w_n;
    logic [7:0]    w_cmask, w_freev;
    logic          w_free_valid;
    logic [CW-1:0] w_free;
    logic [TB-1:0] w_delta, w_eff;
    logic          w_ov, w_cond, w_is_occ, w_take, w_change, w_out_free;
    logic [TW-1:0] w_oi;
    logic [CW-1:0] w_src_core, w_c0;

    // cores in use, saturated to 1..8
    always_comb begin
        if (r_ncfg == 4'd0)      w_n = 4'd1;
        else if (r_ncfg > 4'd8)  w_n = 4'd8;
        else                     w_n = r_ncfg;
        for (int i = 0; i < 8; i++) begin
            w_cmask[i] = (4'(i) < w_n);
        end
    end

    // lowest free core the event thread may use
    always_comb begin
        w_freev      = r_aff[r_t] & w_cmask;
        for (int i = 0; i < NC; i++) begin
            if (r_occv[i]) w_freev[i] = 1'b0;
        end
        w_free_valid = |w_freev;
        w_free       = '0;
        for (int i = NC - 1; i >= 0; i--) begin
            if (w_freev[i]) w_free = CW'(i);
        end
    end

    // scan of one thread against core r_rc
    assign w_ov     = r_occv[r_rc];
    assign w_oi     = r_occ[r_rc];
    assign w_cond   = r_aff[r_st][r_rc] && r_run[r_st] && (r_onv[r_st] || r_onc[r_st] == r_rc);
    assign w_is_occ = w_ov && (w_oi == r_st);
    assign w_eff    = w_is_occ ? r_now : r_last[r_st];
    assign w_take   = w_cond && (!r_pv || w_eff < r_best);
    assign w_change = (w_ov != r_pv) || (w_ov && r_pv && (w_oi != r_pick));

    assign w_delta    = r_now - r_prev;
    assign w_out_free = !r_ov || o_res.ready;
    assign w_c0       = ({1'b0, r_nic} >= w_n) ? '0 : r_nic;

    always_comb begin
        case (i_cmd.src)
            aqts_pkg::SRC_ON:   w_src_core = r_onc[r_t];
            aqts_pkg::SRC_FREE: w_src_core = w_free;
            aqts_pkg::SRC_YC:   w_src_core = r_yc;
            default:            w_src_core = r_tc;
        endcase
    end

    // status towards the controller
    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.created    = r_cre[r_t];
        o_stat.runnable   = r_run[r_t];
        o_stat.on_none    = r_onv[r_t];
        o_stat.on_allowed = r_aff[r_t][r_onc[r_t]];
        o_stat.yc_allowed = r_aff[r_t][r_yc];
        o_stat.self       = (r_t == r_caller);
        o_stat.mask_bad   = r_given && (r_mask == 8'd0 || (r_mask & ~w_cmask) != 8'd0);
        o_stat.free_valid = w_free_valid;
        o_stat.occ_start  = w_ov && r_start[w_oi];
        o_stat.scan_last  = (r_st == TW'(NT - 1));
        o_stat.need_out   = w_change && w_ov;
        o_stat.need_in    = w_change && r_pv;
        o_stat.tick_need  = (32'(w_delta) > r_slice[r_tc]) || !r_occv[r_tc];
        o_stat.tick_last  = ({1'b0, r_tc} == (w_n - 4'd1));
        o_stat.out_free   = w_out_free;
    end

    assign o_res.valid       = r_ov;
    assign o_res.result_kind = r_okind;
    assign o_res.moved_thread = r_oth;
    assign o_res.core_index  = r_ocore;
    assign o_res.core_valid  = r_ocv;
    assign o_res.reply_ok    = r_ook;
    assign o_res.reply_mask  = r_omask;
    assign o_res.last_result = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NT; i++) begin
                r_aff[i]   <= '0;
                r_run[i]   <= 1'b0;
                r_start[i] <= 1'b0;
                r_cre[i]   <= 1'b0;
                r_onv[i]   <= 1'b1;
                r_last[i]  <= '0;
            end
            for (int i = 0; i < NC; i++) begin
                r_occv[i]  <= 1'b0;
                r_slice[i] <= '0;
            end
            r_prev  <= '0;
            r_nic   <= '0;
            r_quant <= aqts_pkg::QUANTUM_RESET;
            r_ncfg  <= aqts_pkg::CORES_RESET;
            r_ov    <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                if (i_cfg_idx == aqts_pkg::IDX_QUANTUM) r_quant <= i_cfg_data;
                else if (i_cfg_idx == aqts_pkg::IDX_CORES) r_ncfg <= i_cfg_data[3:0];
            end
            if (o_res.ready) r_ov <= 1'b0;

            case (i_cmd.op)
                aqts_pkg::OP_LOAD: begin
                    r_cmd    <= i_item.command;
                    r_t      <= i_item.thread_index;
                    r_caller <= i_item.caller_index;
                    r_mask   <= i_item.affinity_mask;
                    r_given  <= i_item.mask_given;
                    r_now    <= i_item.event_time;
                    r_ok     <= 1'b1;
                    r_rcore  <= '0;
                    r_rcv    <= 1'b0;
                    r_rmask  <= '0;
                end
                aqts_pkg::OP_REJECT: r_ok <= 1'b0;
                aqts_pkg::OP_CREATE1: begin
                    r_cre[r_t]   <= 1'b1;
                    r_start[r_t] <= 1'b1;
                    if (r_aff[r_t] == 8'd0) begin
                        r_aff[r_t] <= 8'd1 << w_c0;
                        r_nic      <= (({1'b0, w_c0} + 4'd1) >= w_n) ? '0 : w_c0 + CW'(1);
                    end
                end
                aqts_pkg::OP_CREATE2: begin
                    r_onv[r_t] <= !w_free_valid;
                    r_onc[r_t] <= w_free;
                    if (w_free_valid) begin
                        r_occv[w_free]  <= 1'b1;
                        r_occ[w_free]   <= r_t;
                        r_slice[w_free] <= r_quant;
                        r_rcore         <= w_free;
                        r_rcv           <= 1'b1;
                    end
                end
                aqts_pkg::OP_SETAFF1: begin
                    if (r_given) begin
                        if (r_mask == 8'd0 || (r_mask & ~w_cmask) != 8'd0) r_ok <= 1'b0;
                        else r_aff[r_t] <= r_mask;
                    end else begin
                        r_aff[r_t] <= r_aff[r_t] | w_cmask;
                    end
                end
                aqts_pkg::OP_GETAFF: r_rmask <= r_aff[r_t] & w_cmask;
                aqts_pkg::OP_RUN1: begin
                    if (r_cmd == aqts_pkg::CMD_START) r_start[r_t] <= 1'b0;
                    r_run[r_t] <= 1'b1;
                end
                aqts_pkg::OP_STOP1: begin
                    if (r_cmd == aqts_pkg::CMD_EXIT) r_start[r_t] <= 1'b0;
                    r_run[r_t] <= 1'b0;
                end
                aqts_pkg::OP_SLICE_CLR_ON: r_slice[r_onc[r_t]] <= '0;
                aqts_pkg::OP_YIELD_SET: begin
                    r_yc                 <= r_onc[r_t];
                    r_slice[r_onc[r_t]]  <= '0;
                end
                aqts_pkg::OP_RS_BEGIN: begin
                    r_rc <= w_src_core;
                    r_st <= '0;
                    r_pv <= 1'b0;
                end
                // oldest eligible thread wins, ties to the lower id
                aqts_pkg::OP_RS_SCAN: begin
                    if (w_cond && w_is_occ) r_last[r_st] <= r_now;
                    if (w_take) begin
                        r_pv   <= 1'b1;
                        r_pick <= r_st;
                        r_best <= w_eff;
                    end
                    r_st <= r_st + TW'(1);
                end
                aqts_pkg::OP_RS_OUT: begin
                    r_onv[w_oi]  <= 1'b1;
                    r_last[w_oi] <= r_now;
                    r_ov    <= 1'b1;
                    r_okind <= 1'b0;
                    r_oth   <= w_oi;
                    r_ocore <= '0;
                    r_ocv   <= 1'b0;
                    r_ook   <= 1'b0;
                    r_omask <= '0;
                    r_olast <= 1'b0;
                end
                aqts_pkg::OP_RS_COMMIT: begin
                    if (w_change) begin
                        r_occv[r_rc] <= r_pv;
                        r_occ[r_rc]  <= r_pick;
                        if (r_pv) begin
                            r_onv[r_pick] <= 1'b0;
                            r_onc[r_pick] <= r_rc;
                            r_ov    <= 1'b1;
                            r_okind <= 1'b0;
                            r_oth   <= r_pick;
                            r_ocore <= r_rc;
                            r_ocv   <= 1'b1;
                            r_ook   <= 1'b0;
                            r_omask <= '0;
                            r_olast <= 1'b0;
                        end
                    end
                    r_slice[r_rc] <= r_quant;
                end
                aqts_pkg::OP_TICK_INIT: r_tc <= '0;
                aqts_pkg::OP_TICK_DEC:  r_slice[r_tc] <= r_slice[r_tc] - 32'(w_delta);
                aqts_pkg::OP_TICK_NEXT: r_tc <= r_tc + CW'(1);
                aqts_pkg::OP_TICK_END:  r_prev <= r_now;
                aqts_pkg::OP_REPLY: begin
                    r_ov    <= 1'b1;
                    r_okind <= 1'b1;
                    r_oth   <= '0;
                    r_ocore <= r_rcv ? r_rcore : '0;
                    r_ocv   <= r_rcv;
                    r_ook   <= r_ok;
                    r_omask <= r_rmask;
                    r_olast <= 1'b1;
                end
                default: ;
            endcase
        end
    end

endmodule

### design/affinity_quantum_thread_scheduler_top.sv
// Affinity quantum thread scheduler, top level.
// Channel i_in carries events (create, set/get affinity, yield, start, stall,
// resume, exit, tick), one item at a time; channel o_res returns, per event, the
// thread move notices in order followed by one reply item with last_result set.
// Configuration: i_cfg_we with i_cfg_idx 0 writes quantum_ticks, index 1 writes
// cores_in_use; other indexes are ignored. Write only while idle.
// Each core reschedule scans the threads against that core, one thread per cycle,
// and ends without a scan when the occupant is still starting. A tick visits every
// core in use. i_in.ready is high only between events. Results leave through a
// single output register; a stall on o_res holds the sequencer at the next result
// it has to emit, and no result is lost or repeated.
// Reset (i_rst_n low, synchronous) resets the thread flags, masks and times, the
// core valid flags and slices, the tick time and the initial core pointer, and
// loads quantum 100000 and eight cores.
// Depends on aqts_pkg, aqts_if, aqts_ctrl and aqts_dp.
module affinity_quantum_thread_scheduler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    aqts_in_if.sink     i_in,
    aqts_out_if.source  o_res
);

    aqts_pkg::t_item    w_item;
    aqts_pkg::t_dp_cmd  w_cmd;
    aqts_pkg::t_dp_stat w_stat;
    logic               w_ready;

    assign i_in.ready = w_ready;

    // payload of the event channel
    assign w_item.command       = i_in.command;
    assign w_item.thread_index  = i_in.thread_index;
    assign w_item.caller_index  = i_in.caller_index;
    assign w_item.affinity_mask = i_in.affinity_mask;
    assign w_item.mask_given    = i_in.mask_given;
    assign w_item.event_time    = i_in.event_time;

    aqts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (w_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    aqts_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (w_item),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_res      (o_res)
    );

endmodule
